// ===== hdl/fermat_factor_key_recovery_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion macros for the key recovery block.
// ----------------------------------------------------------------------------
`ifndef FERMAT_FACTOR_KEY_RECOVERY_MACROS_SVH
`define FERMAT_FACTOR_KEY_RECOVERY_MACROS_SVH
`ifndef ASSERT_OFF
`define FFKR_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define FFKR_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define FFKR_ASSERT(label, clk, rst_n, prop, msg)
`define FFKR_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

// ===== hdl/ffkr_pkg.sv =====
// ----------------------------------------------------------------------------
// Fermat key recovery package
// Types, widths and codes shared by the key recovery modules.
// ----------------------------------------------------------------------------
package ffkr_pkg;
  localparam int unsigned NW = 31;
  localparam int unsigned HW = 16;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EVEN    = 2'd1;
  localparam logic [1:0] ST_PRIME   = 2'd2;
  localparam logic [1:0] ST_NO_INV  = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE, S_SQRT, S_FIXC, S_TRY, S_DIV, S_CHECK, S_PHI,
    S_EDIV, S_EUC, S_EUPD, S_FIN, S_OUT
  } state_e;

  typedef enum logic [3:0] {
    C_NONE, C_LOAD, C_SQRT_STEP, C_FIXC, C_DIV_START, C_DIV_STEP, C_STEP_C,
    C_PHI, C_EUC_START, C_EUC_UPD, C_FIN, C_SET_EVEN, C_SET_PRIME
  } cmd_e;

  typedef struct packed {
    logic n_even;
    logic sqrt_done;
    logic div_done;
    logic rem_zero;
    logic c_small;
    logic r1_zero;
  } stat_t;

  typedef struct packed {
    logic [HW-1:0] small_factor;
    logic [NW-1:0] large_factor;
    logic [NW-1:0] totient;
    logic [NW-1:0] priv_exponent;
    logic [1:0]    status;
  } result_t;
endpackage

// ===== hdl/ffkr_if.sv =====
// ----------------------------------------------------------------------------
// Key recovery channels
// Valid/ready channel interfaces for input and result words.
// ----------------------------------------------------------------------------
interface ffkr_in_if;
  logic                 valid;
  logic                 ready;
  logic [ffkr_pkg::NW-1:0] pub_exponent;
  logic [ffkr_pkg::NW-1:0] modulus;
  modport source (output valid, pub_exponent, modulus, input ready);
  modport sink (input valid, pub_exponent, modulus, output ready);
endinterface

interface ffkr_out_if;
  logic                 valid;
  logic                 ready;
  logic [ffkr_pkg::HW-1:0] small_factor;
  logic [ffkr_pkg::NW-1:0] large_factor;
  logic [ffkr_pkg::NW-1:0] totient;
  logic [ffkr_pkg::NW-1:0] priv_exponent;
  logic [1:0]           status;
  modport source (output valid, small_factor, large_factor, totient, priv_exponent, status,
                  input ready);
  modport sink (input valid, small_factor, large_factor, totient, priv_exponent, status,
                output ready);
endinterface

// ===== hdl/ffkr_datapath.sv =====
// ----------------------------------------------------------------------------
// Key recovery datapath
// Square root, restoring divider, candidate scan and extended Euclid.
// ----------------------------------------------------------------------------
module ffkr_datapath (
  input  logic                    clk_i,
  input  ffkr_pkg::cmd_e          cmd_i,
  input  logic [ffkr_pkg::NW-1:0] e_i,
  input  logic [ffkr_pkg::NW-1:0] n_i,
  output ffkr_pkg::stat_t         stat_o,
  output ffkr_pkg::result_t       res_o
);
  import ffkr_pkg::*;

  localparam int unsigned CW = $clog2(NW + 1);
  localparam int unsigned SW = $clog2(HW + 1);

  logic [NW-1:0] e_q, n_q, sv_q, sr_q, c_q, q_q;
  logic [SW-1:0] sk_q;
  logic [NW-1:0] dvd_q, dvs_q, quo_q, rem_q;
  logic [CW-1:0] dk_q;
  logic [NW-1:0] phi_q, r0_q, r1_q;
  logic signed [NW+1:0] t0_q, t1_q;
  result_t       res_q;

  logic [NW-1:0] bit_w, trial_w;
  logic [NW:0]   rsh_w;
  logic signed [2*NW+3:0] prod_w;
  logic signed [NW+1:0] tfix_w;

  assign bit_w   = NW'(1) << {sk_q, 1'b0};
  assign trial_w = sr_q + bit_w;
  assign rsh_w   = {rem_q, dvd_q[NW-1]};
  assign prod_w  = $signed({2'b00, quo_q}) * t1_q;
  assign tfix_w  = t0_q + $signed({2'b00, phi_q});

  always_ff @(posedge clk_i) begin
    case (cmd_i)
      C_LOAD: begin
        e_q <= e_i; n_q <= n_i; sv_q <= n_i; sr_q <= '0;
        sk_q <= SW'(HW - 1);
      end
      C_SQRT_STEP: begin
        if (sv_q >= trial_w) begin
          sv_q <= sv_q - trial_w;
          sr_q <= (sr_q >> 1) + bit_w;
        end else begin
          sr_q <= sr_q >> 1;
        end
        sk_q <= sk_q - SW'(1);
      end
      C_FIXC: c_q <= sr_q[0] ? sr_q : sr_q - NW'(1);
      C_STEP_C: c_q <= c_q - NW'(2);
      C_DIV_START: begin
        dvd_q <= n_q; dvs_q <= c_q; quo_q <= '0; rem_q <= '0; dk_q <= CW'(NW);
      end
      C_DIV_STEP: begin
        if (rsh_w >= {1'b0, dvs_q}) begin
          rem_q <= NW'(rsh_w - {1'b0, dvs_q});
          quo_q <= {quo_q[NW-2:0], 1'b1};
        end else begin
          rem_q <= rsh_w[NW-1:0];
          quo_q <= {quo_q[NW-2:0], 1'b0};
        end
        dvd_q <= dvd_q << 1;
        dk_q  <= dk_q - CW'(1);
      end
      C_PHI: begin
        q_q   <= quo_q;
        phi_q <= NW'((c_q - NW'(1)) * (quo_q - NW'(1)));
        r0_q  <= NW'((c_q - NW'(1)) * (quo_q - NW'(1)));
        r1_q  <= e_q;
        t0_q  <= '0; t1_q <= 'sd1;
      end
      C_EUC_START: begin
        dvd_q <= r0_q; dvs_q <= r1_q; quo_q <= '0; rem_q <= '0; dk_q <= CW'(NW);
      end
      C_EUC_UPD: begin
        r0_q <= r1_q; r1_q <= rem_q;
        t0_q <= t1_q; t1_q <= t0_q - (NW+2)'(prod_w);
      end
      C_FIN: begin
        if (r0_q == NW'(1)) begin
          res_q <= '{small_factor: c_q[HW-1:0], large_factor: q_q, totient: phi_q,
                     priv_exponent: (t0_q < 0) ? tfix_w[NW-1:0] : t0_q[NW-1:0],
                     status: ST_OK};
        end else begin
          res_q <= '{status: ST_NO_INV, default: '0};
        end
      end
      C_SET_EVEN: res_q <= '{status: ST_EVEN, default: '0};
      C_SET_PRIME: res_q <= '{status: ST_PRIME, default: '0};
      default: ;
    endcase
  end

  assign stat_o.n_even    = ~n_q[0];
  assign stat_o.sqrt_done = (sk_q == '0);
  assign stat_o.div_done  = (dk_q == '0);
  assign stat_o.rem_zero  = (rem_q == '0);
  assign stat_o.c_small   = (c_q <= NW'(1));
  assign stat_o.r1_zero   = (r1_q == '0);
  assign res_o = res_q;
endmodule

// ===== hdl/ffkr_ctrl.sv =====
// ----------------------------------------------------------------------------
// Key recovery controller
// Sequences the search, the divisions and the Euclid iterations.
// ----------------------------------------------------------------------------
`include "fermat_factor_key_recovery_macros.svh"
module ffkr_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  ffkr_pkg::stat_t stat_i,
  output ffkr_pkg::cmd_e  cmd_o
);
  import ffkr_pkg::*;

  state_e state_q, state_d;
  logic   euc_q, euc_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      euc_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      euc_q   <= euc_d;
    end
  end

  always_comb begin
    state_d = state_q;
    euc_d   = euc_q;
    cmd_o   = C_NONE;
    case (state_q)
      S_IDLE: if (in_valid_i) begin cmd_o = C_LOAD; state_d = S_SQRT; end
      S_SQRT: begin
        if (stat_i.n_even) begin
          cmd_o = C_SET_EVEN; state_d = S_OUT;
        end else begin
          cmd_o = C_SQRT_STEP;
          if (stat_i.sqrt_done) state_d = S_FIXC;
        end
      end
      S_FIXC: begin cmd_o = C_FIXC; state_d = S_TRY; end
      S_TRY: begin
        if (stat_i.c_small) begin
          cmd_o = C_SET_PRIME; state_d = S_OUT;
        end else begin
          cmd_o = C_DIV_START; euc_d = 1'b0; state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (stat_i.div_done) state_d = euc_q ? S_EUPD : S_CHECK;
        else cmd_o = C_DIV_STEP;
      end
      S_CHECK: begin
        if (stat_i.rem_zero) begin
          cmd_o = C_PHI; state_d = S_PHI;
        end else begin
          cmd_o = C_STEP_C; state_d = S_TRY;
        end
      end
      S_PHI: begin euc_d = 1'b1; state_d = S_EUC; end
      S_EUC: begin
        if (stat_i.r1_zero) begin
          state_d = S_FIN;
        end else begin
          cmd_o = C_EUC_START; state_d = S_EDIV;
        end
      end
      S_EDIV: begin cmd_o = C_DIV_STEP; state_d = S_DIV; end
      S_EUPD: begin cmd_o = C_EUC_UPD; state_d = S_EUC; end
      S_FIN: begin cmd_o = C_FIN; state_d = S_OUT; end
      S_OUT: if (out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

  `FFKR_ASSERT(a_rdy_excl, clk_i, rst_ni, !(in_ready_o && out_valid_o), "ready while busy")
  `FFKR_ASSERT_NEXT(a_acc, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o, "accept lost")
  `FFKR_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o,
                    "result dropped")
endmodule

// ===== hdl/fermat_factor_key_recovery.sv =====
// ----------------------------------------------------------------------------
// Fermat factorization key recovery
// Factors n near sqrt(n), forms the totient and inverts e modulo it.
// ----------------------------------------------------------------------------
// Usage: present e and n on the input channel; one result word follows each
// input word on the output channel with p, q, totient, d and a status code.
// Sequence: a bit-serial square root, then one trial division per odd
// divisor scanned down from isqrt(n), then one division per Euclid step.
// Worst case (n prime near 2^31) is roughly 23000 trials. The shared
// bit-serial divider, used for the trials and the Euclid steps, dominates.
// One word is worked on at a time; input ready is high only when idle.
// Reset returns the controller to idle and drops any word in progress.
// When the receiver stalls, the result word is held until taken.
// ----------------------------------------------------------------------------
module fermat_factor_key_recovery (
  input logic  clk_i,
  input logic  rst_ni,
  ffkr_in_if.sink    in_if,
  ffkr_out_if.source out_if
);
  import ffkr_pkg::*;

  cmd_e    cmd;
  stat_t   stat;
  result_t res;

  ffkr_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready),
    .stat_i(stat), .cmd_o(cmd)
  );

  ffkr_datapath u_dp (
    .clk_i, .cmd_i(cmd), .e_i(in_if.pub_exponent), .n_i(in_if.modulus),
    .stat_o(stat), .res_o(res)
  );

  assign out_if.small_factor  = res.small_factor;
  assign out_if.large_factor  = res.large_factor;
  assign out_if.totient       = res.totient;
  assign out_if.priv_exponent = res.priv_exponent;
  assign out_if.status        = res.status;
endmodule

// ===== dv/ffkr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key recovery checker
// Watches both channels, predicts the result word for every accepted input
// word, and compares each accepted result word field by field in order.
// ----------------------------------------------------------------------------
module ffkr_checker (
  input  logic clk_i,
  input  logic rst_ni,
  ffkr_in_if   in_w,
  ffkr_out_if  out_w,
  output int   fail_count_o,
  output int   pending_o
);
  import ffkr_pkg::*;

  result_t expected_q[$];

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint unsigned inverse_of(longint unsigned e, longint unsigned m);
    longint t0, t1, t2;
    longint unsigned r0, r1, r2, qt;
    t0 = 0;
    t1 = 1;
    r0 = m;
    r1 = e % m;
    while (r1 != 0) begin
      qt = r0 / r1;
      r2 = r0 - qt * r1;
      t2 = t0 - longint'(qt) * t1;
      r0 = r1;
      r1 = r2;
      t0 = t1;
      t1 = t2;
    end
    if (r0 != 1) return 0;
    if (t0 < 0) return longint'(t0 + longint'(m));
    return t0;
  endfunction

  function automatic result_t recover_key(logic [NW-1:0] e, logic [NW-1:0] n);
    result_t r;
    longint unsigned c, p, q, phi, d;
    r = '0;
    if (!n[0]) begin
      r.status = ST_EVEN;
    end else begin
      c = int_sqrt(n);
      if (!c[0]) c = c - 1;
      while (c > 1 && (n % c) != 0) c = c - 2;
      if (c <= 1) begin
        r.status = ST_PRIME;
      end else begin
        p = c;
        q = n / c;
        phi = (p - 1) * (q - 1);
        d = inverse_of(e, phi);
        if (d == 0) begin
          r.status = ST_NO_INV;
        end else begin
          r.small_factor  = p[HW-1:0];
          r.large_factor  = q[NW-1:0];
          r.totient       = phi[NW-1:0];
          r.priv_exponent = d[NW-1:0];
          r.status        = ST_OK;
        end
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    fail_count_o++;
  endtask

  initial begin
    fail_count_o = 0;
  end

  assign pending_o = expected_q.size();

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni) begin
      if (in_w.valid && in_w.ready) begin
        expected_q.push_back(recover_key(in_w.pub_exponent, in_w.modulus));
      end
      if (out_w.valid && out_w.ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected word", out_w.status, 0);
        end else begin
          want = expected_q.pop_front();
          if (out_w.small_factor !== want.small_factor)
            report_mismatch("small_factor", out_w.small_factor, want.small_factor);
          if (out_w.large_factor !== want.large_factor)
            report_mismatch("large_factor", out_w.large_factor, want.large_factor);
          if (out_w.totient !== want.totient)
            report_mismatch("totient", out_w.totient, want.totient);
          if (out_w.priv_exponent !== want.priv_exponent)
            report_mismatch("priv_exponent", out_w.priv_exponent, want.priv_exponent);
          if (out_w.status !== want.status)
            report_mismatch("status", out_w.status, want.status);
        end
      end
    end
  end
endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key recovery testbench
// Drives directed and random keys with bursty input and a stalling receiver,
// and gives the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb_top;
  import ffkr_pkg::*;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;
  int   long_hold;

  ffkr_in_if  in_w ();
  ffkr_out_if out_w ();

  fermat_factor_key_recovery dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_w),
    .out_if (out_w)
  );

  ffkr_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_w         (in_w),
    .out_w        (out_w),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("[fermat_factor_key_recovery] ERROR");
    $finish;
  end

  task automatic send_word(logic [NW-1:0] e, logic [NW-1:0] n);
    in_w.valid        <= 1'b1;
    in_w.pub_exponent <= e;
    in_w.modulus      <= n;
    do @(posedge clk_i); while (!in_w.ready);
    @(negedge clk_i);
  endtask

  task automatic maybe_gap();
    int gap;
    if ($urandom_range(0, 2) == 0) begin
      gap = $urandom_range(1, 12);
      in_w.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic random_word(output logic [NW-1:0] e, output logic [NW-1:0] n);
    longint unsigned p, q;
    case ($urandom_range(0, 3))
      0: e = 31'd65537;
      1: e = 31'd3;
      2: e = NW'($urandom_range(1, 1000));
      default: e = NW'($urandom());
    endcase
    case ($urandom_range(0, 9))
      0: begin
        n = NW'($urandom());
        n[0] = 1'b0;
      end
      1, 2: n = NW'($urandom_range(3, 4095)) | 31'd1;
      default: begin
        p = $urandom_range(3, 46339) | 1;
        q = p + 2 * $urandom_range(0, 400);
        if (p * q > 64'h7FFF_FFFF) q = p;
        n = NW'(p * q);
      end
    endcase
  endtask

  // The receiver takes words on a stall pattern of its own; a nonzero value in
  // long_hold keeps it off until that count has run down to zero.
  initial begin
    int phase;
    out_w.ready = 1'b0;
    phase = 0;
    forever begin
      @(negedge clk_i);
      phase++;
      if (long_hold > 0) begin
        out_w.ready <= 1'b0;
        long_hold--;
      end else if ((phase / 200) % 3 == 0) begin
        out_w.ready <= 1'b1;
      end else begin
        out_w.ready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  initial begin
    logic [NW-1:0] e, n;
    logic [NW-1:0] dir_e[$];
    logic [NW-1:0] dir_n[$];
    long_hold = 0;
    rst_ni = 1'b0;
    in_w.valid = 1'b0;
    in_w.pub_exponent = '0;
    in_w.modulus = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    dir_e = '{31'd3, 31'd65537, 31'd7, 31'd1, 31'd0, 31'd4, 31'h7FFF_FFFF, 31'd3,
              31'd5, 31'd5, 31'd5, 31'd5, 31'd65537, 31'h7FFF_FFFF, 31'd17, 31'd11,
              31'h5555_5555, 31'h2AAA_AAAB};
    dir_n = '{31'd9, 31'd49, 31'd15, 31'd15, 31'd15, 31'd15, 31'd15, 31'd3,
              31'd97, 31'd65521, 31'd4, 31'h7FFF_FFFE, 31'd2147210243, 31'd2147210243,
              31'd2147302921, 31'd143, 31'd3233, 31'd3233};
    foreach (dir_n[i]) begin
      send_word(dir_e[i], dir_n[i]);
      maybe_gap();
    end

    for (int i = 0; i < 100; i++) begin
      random_word(e, n);
      if (i == 30) long_hold = 3000;
      if (i == 60) begin
        in_w.valid <= 1'b0;
        wait (pending == 0);
        @(negedge clk_i);
      end
      send_word(e, n);
      maybe_gap();
    end
    in_w.valid <= 1'b0;

    wait (pending == 0);
    repeat (200) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[fermat_factor_key_recovery] OK");
    end else begin
      $display("[fermat_factor_key_recovery] ERROR");
    end
    $finish;
  end
endmodule
